### rtl/csm_pkg.sv
// csm_pkg: shared types and constants for the complex subband morph block
// used by every module under rtl; no dependencies
`timescale 1ns / 1ps

package csm_pkg;

  localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [15:0] RAMP_DEFAULT = 16'd960;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } csm_op_t;

  typedef enum logic [2:0] {
    REG_MAG_TARGET,
    REG_PHASE_TARGET,
    REG_THR_TARGET,
    REG_BYPASS_LOW,
    REG_BYPASS_HIGH,
    REG_RAMP_SAMPLES
  } csm_reg_t;

  // command to the shared arithmetic unit
  typedef struct packed {
    logic        start;
    csm_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
    logic [6:0]  k;
  } csm_cmd_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } csm_rsp_t;

  typedef struct packed {
    logic [16:0] mag;
    logic [16:0] phase;
    logic [23:0] thr;
  } csm_tgt_t;

  typedef struct packed {
    logic        restart;
    logic        snap;
    logic [15:0] count;
  } csm_restart_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_STEP,
    S_ADV,
    S_RAMP,
    S_MSQ0,
    S_MSQ1,
    S_MSQRT,
    S_SSQ0,
    S_SSQ1,
    S_SSQRT,
    S_MUX,
    S_MUY,
    S_SUX,
    S_SUY,
    S_OMAG,
    S_GMUL,
    S_GDIV,
    S_LX,
    S_LY,
    S_LSQ0,
    S_LSQ1,
    S_LSQRT,
    S_ORE_MUL,
    S_ORE_DIV,
    S_OIM_MUL,
    S_OIM_DIV,
    S_DONE
  } csm_state_t;

endpackage

### rtl/csm_arith_unit.sv
// csm_arith_unit: shared iterative unit, shift-add multiply, restoring divide, square root
// one bit (or one root digit) per cycle; uses csm_pkg
`timescale 1ns / 1ps

module csm_arith_unit (
  input  logic              clk,
  input  logic              rst,
  input  csm_pkg::csm_cmd_t cmd,
  output csm_pkg::csm_rsp_t rsp
);
  import csm_pkg::*;

  logic        busy;
  logic        done;
  logic [6:0]  cnt;
  csm_op_t     op;
  logic [63:0] x, y, z;
  logic [63:0] x_next, y_next, z_next;
  logic [63:0] div_t, sq_r, sq_t;
  logic [6:0]  div_sh, sq_sh;

  assign div_sh = 7'd64 - cmd.k;
  assign sq_sh  = 7'd64 - {cmd.k[5:0], 1'b0};

  always_comb begin
    x_next = x;
    y_next = y;
    z_next = z;
    div_t  = {z[62:0], x[63]};
    sq_r   = {z[61:0], x[63:62]};
    sq_t   = {y[61:0], 2'b01};
    unique case (op)
      OP_MUL: begin
        if (y[0]) z_next = z + x;
        x_next = {x[62:0], 1'b0};
        y_next = {1'b0, y[63:1]};
      end
      OP_DIV: begin
        // x shifts dividend bits out the top and quotient bits in the bottom
        if (div_t >= y) begin
          z_next = div_t - y;
          x_next = {x[62:0], 1'b1};
        end else begin
          z_next = div_t;
          x_next = {x[62:0], 1'b0};
        end
      end
      OP_SQRT: begin
        x_next = {x[61:0], 2'b00};
        if (sq_r >= sq_t) begin
          z_next = sq_r - sq_t;
          y_next = {y[62:0], 1'b1};
        end else begin
          z_next = sq_r;
          y_next = {y[62:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.k;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op <= cmd.op;
      unique case (cmd.op)
        OP_MUL: begin
          x <= cmd.a;
          y <= cmd.b;
          z <= '0;
        end
        OP_DIV: begin
          x <= cmd.a << div_sh;
          y <= cmd.b;
          z <= cmd.a >> cmd.k;
        end
        OP_SQRT: begin
          x <= cmd.a << sq_sh;
          y <= '0;
          z <= '0;
        end
        default: begin
          x <= cmd.a;
          y <= cmd.b;
          z <= '0;
        end
      endcase
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  always_comb begin
    rsp.done = done;
    unique case (op)
      OP_DIV:  rsp.res = x;
      OP_SQRT: rsp.res = y;
      default: rsp.res = z;
    endcase
  end

endmodule

### rtl/csm_cfg.sv
// csm_cfg: configuration registers, weight saturation and ramp restart events
// uses csm_pkg
`timescale 1ns / 1ps

module csm_cfg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [2:0]            cfg_index,
  input  logic [23:0]           cfg_data,
  output csm_pkg::csm_tgt_t     tgt,
  output logic                  bypass_low,
  output logic                  bypass_high,
  output csm_pkg::csm_restart_t restart
);
  import csm_pkg::*;

  logic [15:0] ramp_samples;
  logic [16:0] wsat;
  logic        tgt_change;

  assign wsat = (cfg_data[16:0] > WEIGHT_ONE) ? WEIGHT_ONE : cfg_data[16:0];

  // a target write that changes the held value restarts the shared ramp
  assign tgt_change = cfg_write_en &&
    ((csm_reg_t'(cfg_index) == REG_MAG_TARGET   && wsat != tgt.mag) ||
     (csm_reg_t'(cfg_index) == REG_PHASE_TARGET && wsat != tgt.phase) ||
     (csm_reg_t'(cfg_index) == REG_THR_TARGET   && cfg_data != tgt.thr));

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt          <= '0;
      bypass_low   <= 1'b0;
      bypass_high  <= 1'b0;
      ramp_samples <= RAMP_DEFAULT;
      restart      <= '0;
    end else begin
      restart <= '{restart: tgt_change, snap: (ramp_samples == 16'd0), count: ramp_samples};
      if (cfg_write_en) begin
        unique case (csm_reg_t'(cfg_index))
          REG_MAG_TARGET: begin
            if (wsat != tgt.mag) tgt.mag <= wsat;
          end
          REG_PHASE_TARGET: begin
            if (wsat != tgt.phase) tgt.phase <= wsat;
          end
          REG_THR_TARGET: begin
            if (cfg_data != tgt.thr) tgt.thr <= cfg_data;
          end
          REG_BYPASS_LOW:   bypass_low   <= cfg_data[0];
          REG_BYPASS_HIGH:  bypass_high  <= cfg_data[0];
          REG_RAMP_SAMPLES: ramp_samples <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### rtl/csm_seq.sv
// csm_seq: item sequencer, ramp state and working registers around the shared unit
// uses csm_pkg; drives csm_arith_unit through csm_cmd_t / csm_rsp_t
`timescale 1ns / 1ps

module csm_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_take,
  input  logic signed [23:0]    main_re,
  input  logic signed [23:0]    main_im,
  input  logic signed [23:0]    side_re,
  input  logic signed [23:0]    side_im,
  input  logic [15:0]           node_id,
  input  logic                  first_channel,
  input  csm_pkg::csm_tgt_t     tgt,
  input  logic                  bypass_low,
  input  logic                  bypass_high,
  input  csm_pkg::csm_restart_t restart,
  input  csm_pkg::csm_rsp_t     rsp,
  output csm_pkg::csm_cmd_t     cmd,
  output logic                  idle,
  output logic                  res_valid,
  input  logic                  res_take,
  output logic signed [23:0]    res_re,
  output logic signed [23:0]    res_im,
  output logic                  res_pt
);
  import csm_pkg::*;

  localparam logic signed [23:0] UNIT_ONE   = 24'sd4194304;
  localparam logic [23:0]        THRESH_MAX = 24'hFFFFFF;

  function automatic logic [23:0] abs24(input logic signed [23:0] v);
    abs24 = v[23] ? 24'(-v) : 24'(v);
  endfunction

  function automatic logic [23:0] abs25(input logic signed [24:0] v);
    logic signed [24:0] n;
    n = -v;
    abs25 = v[24] ? n[23:0] : v[23:0];
  endfunction

  function automatic logic signed [23:0] sat26(input logic signed [25:0] v);
    if (v > 26'sd8388607) sat26 = 24'sh7FFFFF;
    else if (v < -26'sd8388608) sat26 = signed'(24'h800000);
    else sat26 = v[23:0];
  endfunction

  csm_state_t state, state_next;
  logic       issued;
  logic       is_call;
  logic [1:0] ridx;

  // ramp state
  logic [23:0] cur [3];
  logic [37:0] step_mag [3];
  logic        step_neg [3];
  logic [15:0] cd;
  logic        pend;
  logic [23:0] tgt_a [3];

  // item and working registers
  logic signed [23:0] mr, mi, sr, si;
  logic [15:0]        node;
  logic               first;
  logic [63:0]        t;
  logic [23:0]        mm, sm, len, om;
  logic signed [23:0] urx, ury, usx, usy, lx, ly;
  logic [16:0]        wp;

  logic               byp;
  logic [23:0]        am_r, am_i, as_r, as_i, alx, aly;
  logic signed [24:0] rdiff, dm, dx, dy;
  logic [23:0]        rdiff_abs, dm_abs, dx_abs, dy_abs;
  logic signed [41:0] rv, om_sum, lx_sum, ly_sum, lx_adj, ly_adj;
  logic [23:0]        rmax, rclamp;
  logic signed [25:0] ore_v, oim_v, q26;
  logic [23:0]        q24;

  assign tgt_a[0] = {7'd0, tgt.mag};
  assign tgt_a[1] = {7'd0, tgt.phase};
  assign tgt_a[2] = tgt.thr;

  assign byp = (bypass_low  && node != 16'd0 && (node & (node - 16'd1)) == 16'd0) ||
               (bypass_high && node != 16'd0 && (node & (node + 16'd1)) == 16'd0);

  assign am_r = abs24(mr);
  assign am_i = abs24(mi);
  assign as_r = abs24(sr);
  assign as_i = abs24(si);
  assign alx  = abs24(lx);
  assign aly  = abs24(ly);

  assign rdiff     = signed'({1'b0, tgt_a[ridx]}) - signed'({1'b0, cur[ridx]});
  assign rdiff_abs = abs25(rdiff);
  assign dm        = signed'({1'b0, sm}) - signed'({1'b0, mm});
  assign dm_abs    = abs25(dm);
  assign dx        = {usx[23], usx} - {urx[23], urx};
  assign dx_abs    = abs25(dx);
  assign dy        = {usy[23], usy} - {ury[23], ury};
  assign dy_abs    = abs25(dy);

  // ramp value: target minus step times countdown over 2^14, clamped
  always_comb begin
    rmax = (ridx == 2'd2) ? THRESH_MAX : {7'd0, WEIGHT_ONE};
    if (step_neg[ridx]) rv = signed'({18'd0, tgt_a[ridx]}) + signed'({2'b0, rsp.res[53:14]});
    else rv = signed'({18'd0, tgt_a[ridx]}) - signed'({2'b0, rsp.res[53:14]});
    if (rv < 42'sd0) rclamp = '0;
    else if (rv > signed'({18'd0, rmax})) rclamp = rmax;
    else rclamp = rv[23:0];
  end

  // blends over the shared product
  always_comb begin
    if (dm[24]) om_sum = signed'({2'b0, mm, 16'd0}) - signed'(rsp.res[41:0]);
    else om_sum = signed'({2'b0, mm, 16'd0}) + signed'(rsp.res[41:0]);
    if (dx[24]) lx_sum = signed'({{2{urx[23]}}, urx, 16'd0}) - signed'({2'b0, rsp.res[39:0]});
    else lx_sum = signed'({{2{urx[23]}}, urx, 16'd0}) + signed'({2'b0, rsp.res[39:0]});
    if (dy[24]) ly_sum = signed'({{2{ury[23]}}, ury, 16'd0}) - signed'({2'b0, rsp.res[39:0]});
    else ly_sum = signed'({{2{ury[23]}}, ury, 16'd0}) + signed'({2'b0, rsp.res[39:0]});
    // round toward zero before the shift
    lx_adj = lx_sum + (lx_sum[41] ? 42'sd65535 : 42'sd0);
    ly_adj = ly_sum + (ly_sum[41] ? 42'sd65535 : 42'sd0);
  end

  always_comb begin
    q24   = rsp.res[23:0];
    q26   = signed'({1'b0, rsp.res[24:0]});
    ore_v = (len == 24'd0) ? signed'({2'b0, om}) : (lx[23] ? -q26 : q26);
    oim_v = (len == 24'd0) ? 26'sd0 : (ly[23] ? -q26 : q26);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_take) state_next = S_CHECK;
      S_CHECK: begin
        priority if (byp) state_next = S_DONE;
        else if (pend) state_next = S_STEP;
        else if (first) state_next = S_ADV;
        else state_next = S_MSQ0;
      end
      S_STEP:  if (rsp.done && ridx == 2'd2) state_next = first ? S_ADV : S_MSQ0;
      S_ADV:   state_next = (cd > 16'd1) ? S_RAMP : S_MSQ0;
      S_RAMP:  if (rsp.done && ridx == 2'd2) state_next = S_MSQ0;
      S_MSQ0:    if (rsp.done) state_next = S_MSQ1;
      S_MSQ1:    if (rsp.done) state_next = S_MSQRT;
      S_MSQRT:   if (rsp.done) state_next = S_SSQ0;
      S_SSQ0:    if (rsp.done) state_next = S_SSQ1;
      S_SSQ1:    if (rsp.done) state_next = S_SSQRT;
      S_SSQRT:   if (rsp.done) state_next = S_MUX;
      S_MUX:     if (rsp.done) state_next = S_MUY;
      S_MUY:     if (rsp.done) state_next = S_SUX;
      S_SUX:     if (rsp.done) state_next = S_SUY;
      S_SUY:     if (rsp.done) state_next = S_OMAG;
      S_OMAG:    if (rsp.done) state_next = S_GMUL;
      S_GMUL:    if (rsp.done) state_next = S_GDIV;
      S_GDIV:    if (rsp.done) state_next = S_LX;
      S_LX:      if (rsp.done) state_next = S_LY;
      S_LY:      if (rsp.done) state_next = S_LSQ0;
      S_LSQ0:    if (rsp.done) state_next = S_LSQ1;
      S_LSQ1:    if (rsp.done) state_next = S_LSQRT;
      S_LSQRT:   if (rsp.done) state_next = S_ORE_MUL;
      S_ORE_MUL: if (rsp.done) state_next = S_ORE_DIV;
      S_ORE_DIV: if (rsp.done) state_next = S_OIM_MUL;
      S_OIM_MUL: if (rsp.done) state_next = S_OIM_DIV;
      S_OIM_DIV: if (rsp.done) state_next = S_DONE;
      S_DONE:    if (res_take) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // unit commands
  always_comb begin
    is_call = 1'b1;
    cmd.op  = OP_MUL;
    cmd.a   = '0;
    cmd.b   = '0;
    cmd.k   = 7'd24;
    unique case (state)
      S_STEP: begin
        cmd.op = OP_DIV;
        cmd.a  = {26'd0, rdiff_abs, 14'd0};
        cmd.b  = {48'd0, cd};
        cmd.k  = 7'd40;
      end
      S_RAMP: begin
        cmd.a = {26'd0, step_mag[ridx]};
        cmd.b = {48'd0, cd};
        cmd.k = 7'd16;
      end
      S_MSQ0: begin cmd.a = {40'd0, am_r}; cmd.b = {40'd0, am_r}; end
      S_MSQ1: begin cmd.a = {40'd0, am_i}; cmd.b = {40'd0, am_i}; end
      S_SSQ0: begin cmd.a = {40'd0, as_r}; cmd.b = {40'd0, as_r}; end
      S_SSQ1: begin cmd.a = {40'd0, as_i}; cmd.b = {40'd0, as_i}; end
      S_LSQ0: begin cmd.a = {40'd0, alx};  cmd.b = {40'd0, alx};  end
      S_LSQ1: begin cmd.a = {40'd0, aly};  cmd.b = {40'd0, aly};  end
      S_MSQRT, S_SSQRT, S_LSQRT: begin
        cmd.op = OP_SQRT;
        cmd.a  = t;
      end
      S_MUX: begin
        cmd.op = OP_DIV; cmd.a = {18'd0, am_r, 22'd0}; cmd.b = {40'd0, mm}; cmd.k = 7'd23;
      end
      S_MUY: begin
        cmd.op = OP_DIV; cmd.a = {18'd0, am_i, 22'd0}; cmd.b = {40'd0, mm}; cmd.k = 7'd23;
      end
      S_SUX: begin
        cmd.op = OP_DIV; cmd.a = {18'd0, as_r, 22'd0}; cmd.b = {40'd0, sm}; cmd.k = 7'd23;
      end
      S_SUY: begin
        cmd.op = OP_DIV; cmd.a = {18'd0, as_i, 22'd0}; cmd.b = {40'd0, sm}; cmd.k = 7'd23;
      end
      S_OMAG: begin
        cmd.a = {40'd0, dm_abs}; cmd.b = {47'd0, cur[0][16:0]}; cmd.k = 7'd17;
      end
      S_GMUL: begin
        cmd.a = {40'd0, sm}; cmd.b = {47'd0, cur[1][16:0]}; cmd.k = 7'd17;
      end
      S_GDIV: begin
        cmd.op = OP_DIV; cmd.a = t; cmd.b = {39'd0, cur[2], 1'b0}; cmd.k = 7'd17;
      end
      S_LX: begin cmd.a = {40'd0, dx_abs}; cmd.b = {47'd0, wp}; cmd.k = 7'd17; end
      S_LY: begin cmd.a = {40'd0, dy_abs}; cmd.b = {47'd0, wp}; cmd.k = 7'd17; end
      S_ORE_MUL: begin cmd.a = {40'd0, om}; cmd.b = {40'd0, alx}; end
      S_OIM_MUL: begin cmd.a = {40'd0, om}; cmd.b = {40'd0, aly}; end
      S_ORE_DIV, S_OIM_DIV: begin
        cmd.op = OP_DIV; cmd.a = t; cmd.b = {40'd0, len}; cmd.k = 7'd26;
      end
      default: is_call = 1'b0;
    endcase
    cmd.start = is_call && !issued;
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
      ridx   <= '0;
      cd     <= '0;
      pend   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cur[i]      <= '0;
        step_mag[i] <= '0;
        step_neg[i] <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (cmd.start) issued <= 1'b1;
      else if (rsp.done) issued <= 1'b0;

      if (restart.restart) begin
        if (restart.snap) begin
          for (int i = 0; i < 3; i++) cur[i] <= tgt_a[i];
          cd   <= '0;
          pend <= 1'b0;
        end else begin
          cd   <= restart.count;
          pend <= 1'b1;
        end
      end

      unique case (state)
        S_CHECK: ridx <= '0;
        S_STEP: begin
          if (rsp.done) begin
            step_mag[ridx] <= rsp.res[37:0];
            step_neg[ridx] <= rdiff[24];
            if (ridx == 2'd2) begin
              ridx <= '0;
              pend <= 1'b0;
            end else begin
              ridx <= ridx + 2'd1;
            end
          end
        end
        S_ADV: begin
          ridx <= '0;
          if (cd != 16'd0) cd <= cd - 16'd1;
          // last advance lands exactly on the targets
          if (cd == 16'd1) begin
            for (int i = 0; i < 3; i++) cur[i] <= tgt_a[i];
          end
        end
        S_RAMP: begin
          if (rsp.done) begin
            cur[ridx] <= rclamp;
            ridx      <= ridx + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // item payload and working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      mr    <= main_re;
      mi    <= main_im;
      sr    <= side_re;
      si    <= side_im;
      node  <= node_id;
      first <= first_channel;
    end
    if (state == S_CHECK) begin
      res_re <= mr;
      res_im <= mi;
      res_pt <= byp;
    end
    if (rsp.done) begin
      unique case (state)
        S_MSQ0, S_SSQ0, S_LSQ0, S_GMUL, S_ORE_MUL, S_OIM_MUL: t <= rsp.res;
        S_MSQ1, S_SSQ1, S_LSQ1: t <= t + rsp.res;
        S_MSQRT: mm  <= rsp.res[23:0];
        S_SSQRT: sm  <= rsp.res[23:0];
        S_LSQRT: len <= rsp.res[23:0];
        S_MUX: urx <= (mm == 24'd0) ? UNIT_ONE : (mr[23] ? -signed'(q24) : signed'(q24));
        S_MUY: ury <= (mm == 24'd0) ? 24'sd0 : (mi[23] ? -signed'(q24) : signed'(q24));
        S_SUX: usx <= (sm == 24'd0) ? UNIT_ONE : (sr[23] ? -signed'(q24) : signed'(q24));
        S_SUY: usy <= (sm == 24'd0) ? 24'sd0 : (si[23] ? -signed'(q24) : signed'(q24));
        S_OMAG: om <= om_sum[39:16];
        S_GDIV: begin
          // gate the phase weight down when the sidechain is under threshold
          if (sm < cur[2])
            wp <= (rsp.res[16:0] < cur[1][16:0]) ? rsp.res[16:0] : cur[1][16:0];
          else
            wp <= cur[1][16:0];
        end
        S_LX: lx <= lx_adj[39:16];
        S_LY: ly <= ly_adj[39:16];
        S_ORE_DIV: res_re <= sat26(ore_v);
        S_OIM_DIV: res_im <= sat26(oim_v);
        default: ;
      endcase
    end
  end

endmodule

### rtl/complex_subband_morph.sv
// complex_subband_morph: one item in flight; time from input transfer to result is set
// by the shared iterative multiply/divide/sqrt unit (one bit or root digit per cycle,
// 22 calls); first-channel items add a ramp advance, plus ramp multiplies mid-ramp;
// step divides come first on the first non-bypassed item after a target write starts a ramp;
// a bypassed band skips the unit; result held in an output register until transferred
// synchronous active-high reset; ramps idle, weights and threshold zero, ramp length 960
`timescale 1ns / 1ps

module complex_subband_morph (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] main_re,
  input  logic signed [23:0] main_im,
  input  logic signed [23:0] side_re,
  input  logic signed [23:0] side_im,
  input  logic [15:0]        node_id,
  input  logic               first_channel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_re,
  output logic signed [23:0] out_im,
  output logic               passed_through,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import csm_pkg::*;

  csm_tgt_t           tgt;
  csm_restart_t       restart;
  csm_cmd_t           cmd;
  csm_rsp_t           rsp;
  logic               bypass_low, bypass_high;
  logic               seq_idle, res_valid, res_take, res_pt, in_take;
  logic signed [23:0] res_re, res_im;

  assign in_stall = !seq_idle;
  assign in_take  = in_valid && !in_stall;
  // result moves to the output register once it is empty or being transferred
  assign res_take = res_valid && (!out_valid || !out_stall);

  csm_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tgt          (tgt),
    .bypass_low   (bypass_low),
    .bypass_high  (bypass_high),
    .restart      (restart)
  );

  csm_arith_unit u_arith (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  csm_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_take       (in_take),
    .main_re       (main_re),
    .main_im       (main_im),
    .side_re       (side_re),
    .side_im       (side_im),
    .node_id       (node_id),
    .first_channel (first_channel),
    .tgt           (tgt),
    .bypass_low    (bypass_low),
    .bypass_high   (bypass_high),
    .restart       (restart),
    .rsp           (rsp),
    .cmd           (cmd),
    .idle          (seq_idle),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res_re        (res_re),
    .res_im        (res_im),
    .res_pt        (res_pt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_take) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_re         <= res_re;
      out_im         <= res_im;
      passed_through <= res_pt;
    end
  end

endmodule
